// File: hdl/esvm_pkg.sv
// Shared constants, types and arithmetic helpers of the encoder-angle SVPWM modulator.
package esvm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int VOLT_BITS_DEF  = 16;

    localparam int PH_BITS          = 24;
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int DIV_BITS         = 16;
    localparam int DIV_PER_STAGE    = 2;
    localparam int DIV_STAGES       = DIV_BITS / DIV_PER_STAGE;

    localparam logic signed [32:0] CORDIC_X0       = 33'sd652012976;
    localparam logic [16:0]        SQRT3_HALF_Q16  = 17'd56756;
    localparam logic signed [39:0] HALF_Q30        = 40'sd536870912;
    localparam logic signed [39:0] ONE_Q30         = 40'sd1073741824;

    localparam logic [15:0] RST_COUNTS_PER_TURN = 16'd4096;
    localparam logic [21:0] RST_ANGLE_PER_COUNT = 22'd1048576;
    localparam logic [14:0] RST_PHASE_GAIN      = 15'd18919;
    localparam logic [15:0] RST_PWM_PERIOD      = 16'd1000;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNTS_PER_TURN = 8'd0,
        CFG_ANGLE_PER_COUNT = 8'd1,
        CFG_PHASE_GAIN      = 8'd2,
        CFG_PWM_PERIOD      = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [25:0] z;
    } t_cordic;

    // Arctangent of 2^-i in units of 2^-24 turn.
    function automatic logic signed [25:0] atan_turn(input int i);
        logic signed [25:0] a;
        case (i)
            0:  a = 26'sd2097152;
            1:  a = 26'sd1238021;
            2:  a = 26'sd654136;
            3:  a = 26'sd332050;
            4:  a = 26'sd166669;
            5:  a = 26'sd83416;
            6:  a = 26'sd41718;
            7:  a = 26'sd20860;
            8:  a = 26'sd10430;
            9:  a = 26'sd5215;
            10: a = 26'sd2608;
            11: a = 26'sd1304;
            12: a = 26'sd652;
            13: a = 26'sd326;
            14: a = 26'sd163;
            15: a = 26'sd81;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

    // One rotation step; i is a constant at every call site.
    function automatic t_cordic cordic_step(input t_cordic c, input int i);
        t_cordic r;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (c.z >= 0) begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - atan_turn(i);
        end else begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + atan_turn(i);
        end
        return r;
    endfunction

    // One restoring remainder step. A zero divisor leaves the dividend as it is.
    function automatic logic [15:0] div_step(input logic [15:0] rem, input logic b,
                                             input logic [15:0] d);
        logic [16:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[15:0];
    endfunction

    // Round a Q.30 value to Q1.15 with saturation.
    function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = (34'(v) + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            t = 34'sd32767;
        end else if (t < -34'sd32768) begin
            t = -34'sd32768;
        end
        return t[15:0];
    endfunction

endpackage

// File: hdl/encoder_angle_svpwm_modulator.sv
// Top level of the encoder-angle space vector PWM modulator pipeline.
//
// Usage: each input item on the slave stream carries a rotor encoder count and a
// q/d voltage command. The block reduces the count modulo counts_per_turn, scales
// it to an electrical angle, forms cosine and sine with a CORDIC, rotates the
// command, applies the inverse Clarke transform with a gain, injects the min/max
// midpoint, offsets by one half, clamps to 0..1 and scales by the PWM period. One
// result item with three compare values leaves on the master stream per input.
// An item passes a two-bit-per-stage remainder pipeline, the angle multiply, the
// CORDIC setup, stages of two CORDIC iterations each, and nine arithmetic stages
// down to the compare multiply. The pipeline takes one item per cycle while the
// receiver accepts results; every stage holds a valid bit and a stage advances
// whenever the stage after it is empty or advancing, so bubbles close up while the
// receiver stalls. When the receiver holds i_m_axis_tready low, the result stays
// on the output and upstream stages keep filling until the pipeline is full; then
// o_s_axis_tready drops. Nothing is lost or repeated. Reset clears all valid bits
// and loads the default register values. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must write only while no item is in flight,
// which the block does not enforce. Indexes above three are ignored.
module encoder_angle_svpwm_modulator #(
    parameter int ANGLE_BITS = esvm_pkg::ANGLE_BITS_DEF,
    parameter int VOLT_BITS  = esvm_pkg::VOLT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // encoder_count[15:0], volt_q, volt_d; zero padded to whole bytes
    input  logic [((16+2*VOLT_BITS+7)/8)*8-1:0]  i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // compare_a[15:0], compare_b[31:16], compare_c[47:32]
    output logic [47:0]                          o_m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [esvm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [esvm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import esvm_pkg::*;

    localparam int ST_ANG   = DIV_STAGES;
    localparam int ST_PREP  = ST_ANG + 1;
    localparam int ST_Q15   = ST_PREP + CORDIC_STAGES + 1;
    localparam int ST_PROD  = ST_Q15 + 1;
    localparam int ST_Q30   = ST_PROD + 1;
    localparam int ST_VBK   = ST_Q30 + 1;
    localparam int ST_U     = ST_VBK + 1;
    localparam int ST_GAIN  = ST_U + 1;
    localparam int ST_MID   = ST_GAIN + 1;
    localparam int ST_CLAMP = ST_MID + 1;
    localparam int ST_OUT   = ST_CLAMP + 1;
    localparam int NST      = ST_OUT + 1;

    localparam int PW  = 16 + VOLT_BITS;
    localparam int DW  = PW + 1;
    localparam int SHL = (VOLT_BITS < 16) ? 16 - VOLT_BITS : 0;
    localparam int SHR = (VOLT_BITS > 16) ? VOLT_BITS - 16 : 0;

    // Configuration registers.
    logic [15:0] r_cpt;
    logic [21:0] r_apc;
    logic [14:0] r_gain;
    logic [15:0] r_period;

    // Handshake and valid chain.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    // Payload registers.
    logic [15:0]                  r_num [DIV_STAGES];
    logic [15:0]                  r_rem [DIV_STAGES];
    logic [15:0]                  n_rem [DIV_STAGES];
    logic signed [VOLT_BITS-1:0]  r_vq [ST_Q15+1];
    logic signed [VOLT_BITS-1:0]  r_vd [ST_Q15+1];
    logic [ANGLE_BITS-1:0]        r_ang;
    logic [37:0]                  ang_prod;
    t_cordic                      r_cd [CORDIC_STAGES+1];
    t_cordic                      n_cd [CORDIC_STAGES+1];
    logic                         r_neg [CORDIC_STAGES+1];
    logic [PH_BITS-1:0]           prep_p;
    logic signed [25:0]           prep_z;
    logic signed [15:0]           r_cos;
    logic signed [15:0]           r_sin;
    logic signed [PW-1:0]         r_sd;
    logic signed [PW-1:0]         r_cq;
    logic signed [PW-1:0]         r_cd_vd;
    logic signed [PW-1:0]         r_sq;
    logic signed [DW+SHL-1:0]     va_ext;
    logic signed [DW+SHL-1:0]     vb_ext;
    logic signed [33:0]           r_va;
    logic signed [33:0]           r_vb;
    logic signed [33:0]           r_va2;
    logic signed [34:0]           r_vbk;
    logic signed [34:0]           r_u [3];
    logic signed [37:0]           r_v [3];
    logic signed [37:0]           r_v2 [3];
    logic signed [37:0]           r_mid;
    logic signed [37:0]           mn;
    logic signed [37:0]           mx;
    logic [30:0]                  r_w [3];
    logic signed [39:0]           w_raw [3];
    logic [46:0]                  cmp_prod [3];
    logic [15:0]                  r_cmp [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt    <= RST_COUNTS_PER_TURN;
            r_apc    <= RST_ANGLE_PER_COUNT;
            r_gain   <= RST_PHASE_GAIN;
            r_period <= RST_PWM_PERIOD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COUNTS_PER_TURN: r_cpt    <= i_cfg_data[15:0];
                CFG_ANGLE_PER_COUNT: r_apc    <= i_cfg_data[21:0];
                CFG_PHASE_GAIN:      r_gain   <= i_cfg_data[14:0];
                CFG_PWM_PERIOD:      r_period <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        en[NST-1] = !r_vld[NST-1] || i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = {r_cmp[2], r_cmp[1], r_cmp[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Remainder pipeline, two dividend bits per stage, most significant first.
    always_comb begin
        n_rem[0] = div_step(div_step(16'd0, i_s_axis_tdata[15], r_cpt),
                            i_s_axis_tdata[14], r_cpt);
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_rem[s] = div_step(div_step(r_rem[s-1], r_num[s-1][15-2*s], r_cpt),
                                r_num[s-1][14-2*s], r_cpt);
        end
    end

    assign ang_prod = 38'(r_rem[DIV_STAGES-1]) * 38'(r_apc);

    // Angle to CORDIC phase, folded into the right half plane.
    always_comb begin
        prep_p = PH_BITS'(r_ang) << (PH_BITS - ANGLE_BITS);
        prep_z = 26'($signed(prep_p));
    end

    always_comb begin
        n_cd[0] = r_cd[0];
        for (int g = 0; g < CORDIC_STAGES; g++) begin
            n_cd[g+1] = cordic_step(cordic_step(r_cd[g], CORDIC_PER_STAGE * g),
                                    CORDIC_PER_STAGE * g + 1);
        end
    end

    always_comb begin
        va_ext = DW'(r_sd - r_cq);
        vb_ext = DW'(r_cd_vd - r_sq);
    end

    always_comb begin
        mn = r_v[0];
        mx = r_v[0];
        for (int p = 1; p < 3; p++) begin
            if (r_v[p] < mn) begin
                mn = r_v[p];
            end
            if (r_v[p] > mx) begin
                mx = r_v[p];
            end
        end
    end

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            w_raw[p]    = 40'(r_v2[p]) + HALF_Q30 - 40'(r_mid);
            cmp_prod[p] = 47'(r_w[p]) * 47'(r_period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_num[0] <= i_s_axis_tdata[15:0];
            r_rem[0] <= n_rem[0];
            r_vq[0]  <= i_s_axis_tdata[16 +: VOLT_BITS];
            r_vd[0]  <= i_s_axis_tdata[16+VOLT_BITS +: VOLT_BITS];
        end
        for (int s = 1; s < DIV_STAGES; s++) begin
            if (en[s]) begin
                r_num[s] <= r_num[s-1];
                r_rem[s] <= n_rem[s];
            end
        end
        for (int s = 1; s <= ST_Q15; s++) begin
            if (en[s]) begin
                r_vq[s] <= r_vq[s-1];
                r_vd[s] <= r_vd[s-1];
            end
        end
        if (en[ST_ANG]) begin
            r_ang <= ang_prod[16 +: ANGLE_BITS];
        end
        if (en[ST_PREP]) begin
            r_cd[0].x <= CORDIC_X0;
            r_cd[0].y <= '0;
            if (prep_z > 26'sd4194304) begin
                r_cd[0].z <= prep_z - 26'sd8388608;
                r_neg[0]  <= 1'b1;
            end else if (prep_z < -26'sd4194304) begin
                r_cd[0].z <= prep_z + 26'sd8388608;
                r_neg[0]  <= 1'b1;
            end else begin
                r_cd[0].z <= prep_z;
                r_neg[0]  <= 1'b0;
            end
        end
        for (int g = 0; g < CORDIC_STAGES; g++) begin
            if (en[ST_PREP+1+g]) begin
                r_cd[g+1]  <= n_cd[g+1];
                r_neg[g+1] <= r_neg[g];
            end
        end
        if (en[ST_Q15]) begin
            r_cos <= to_q15(r_neg[CORDIC_STAGES] ? -r_cd[CORDIC_STAGES].x
                                                 : r_cd[CORDIC_STAGES].x);
            r_sin <= to_q15(r_neg[CORDIC_STAGES] ? -r_cd[CORDIC_STAGES].y
                                                 : r_cd[CORDIC_STAGES].y);
        end
        if (en[ST_PROD]) begin
            r_sd    <= PW'(r_sin * r_vd[ST_Q15]);
            r_cq    <= PW'(r_cos * r_vq[ST_Q15]);
            r_cd_vd <= PW'(r_cos * r_vd[ST_Q15]);
            r_sq    <= PW'(r_sin * r_vq[ST_Q15]);
        end
        if (en[ST_Q30]) begin
            r_va <= 34'((va_ext <<< SHL) >>> SHR);
            r_vb <= 34'((vb_ext <<< SHL) >>> SHR);
        end
        if (en[ST_VBK]) begin
            r_vbk <= 35'((51'(r_vb) * $signed({1'b0, SQRT3_HALF_Q16[15:0]})) >>> 16);
            r_va2 <= r_va;
        end
        if (en[ST_U]) begin
            r_u[0] <= 35'(r_va2);
            r_u[1] <= r_vbk - 35'(r_va2 >>> 1);
            r_u[2] <= -r_vbk - 35'(r_va2 >>> 1);
        end
        if (en[ST_GAIN]) begin
            for (int p = 0; p < 3; p++) begin
                r_v[p] <= 38'((51'(r_u[p]) * $signed({1'b0, r_gain})) >>> 14);
            end
        end
        if (en[ST_MID]) begin
            r_mid <= 38'((39'(mn) + 39'(mx)) >>> 1);
            for (int p = 0; p < 3; p++) begin
                r_v2[p] <= r_v[p];
            end
        end
        if (en[ST_CLAMP]) begin
            for (int p = 0; p < 3; p++) begin
                if (w_raw[p] < 0) begin
                    r_w[p] <= '0;
                end else if (w_raw[p] > ONE_Q30) begin
                    r_w[p] <= ONE_Q30[30:0];
                end else begin
                    r_w[p] <= w_raw[p][30:0];
                end
            end
        end
        if (en[ST_OUT]) begin
            for (int p = 0; p < 3; p++) begin
                r_cmp[p] <= cmp_prod[p][45:30];
            end
        end
    end

`ifndef SYNTH
    // The remainder stage never leaves a value at or above a nonzero modulus.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DIV_STAGES-1] && r_cpt != 16'd0) |-> (r_rem[DIV_STAGES-1] < r_cpt))
        else $error("remainder out of range");
    // The clamp keeps every compare value within the period.
    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_cmp[0] <= r_period && r_cmp[1] <= r_period
                             && r_cmp[2] <= r_period))
        else $error("compare value above period");
    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");
    // A full pipeline with a stalled receiver refuses new items.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("item accepted into a full pipeline");
`endif

endmodule

// File: verif/tb_encoder_angle_svpwm_modulator.sv
// Self-checking testbench of the encoder-angle SVPWM modulator with its own predictor.
module tb_encoder_angle_svpwm_modulator;
    import esvm_pkg::*;

    // Index with no register behind it; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd4;
    localparam int LATENCY_WAIT   = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int NUM_SETTINGS   = 8;

    typedef struct packed {
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
        logic [15:0] cmp_c;
    } t_compares;

    typedef struct {
        logic [15:0]        count;
        logic signed [15:0] vq;
        logic signed [15:0] vd;
        bit                 typed;
        t_compares          result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    encoder_angle_svpwm_modulator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mirror of the block's registers.
    longint unsigned turn_counts;
    longint unsigned angle_scale;
    longint unsigned gain_q14;
    longint unsigned period;

    t_compares compares_pending[$];
    bit        row_typed = 1'b0;
    t_compares row_result = '0;
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;
    bit        quiet_sender = 1'b0;

    longint atan_table[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                               20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    function automatic longint round_q15(longint q30);
        longint r;
        r = (q30 + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic longint duty_to_compare(longint v, longint mid);
        longint t;
        t = v + (64'sd1 <<< 29) - mid;
        if (t < 0) t = 0;
        if (t > (64'sd1 <<< 30)) t = 64'sd1 <<< 30;
        return ((t * longint'(period)) >>> 30) & 64'hFFFF;
    endfunction

    // Works out the three compare values for one command at the current settings.
    function automatic t_compares predict_compares(logic [15:0] count,
                                                   logic signed [15:0] vq,
                                                   logic signed [15:0] vd);
        longint cnt, ang, ph, z, x, y, dx, dy, cs, sn, va, vb, vbk, hv;
        longint v1, v2, v3, mn, mx, mid, qv, dv;
        bit neg;
        t_compares r;
        cnt = longint'(count);
        if (turn_counts != 0) cnt = cnt % longint'(turn_counts);
        ang = ((cnt * longint'(angle_scale)) >>> 16) & 64'hFFFF;
        ph = (ang <<< 8) & 64'hFFFFFF;
        z = (ph >= (64'sd1 <<< 23)) ? ph - (64'sd1 <<< 24) : ph;
        neg = 1'b0;
        // Fold the angle into the right half plane and negate at the end.
        if (z > (64'sd1 <<< 22)) begin
            z = z - (64'sd1 <<< 23);
            neg = 1'b1;
        end else if (z < -(64'sd1 <<< 22)) begin
            z = z + (64'sd1 <<< 23);
            neg = 1'b1;
        end
        x = 652012976;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_table[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_table[i];
            end
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        cs = round_q15(x);
        sn = round_q15(y);
        qv = longint'(vq);
        dv = longint'(vd);
        va = sn * dv - cs * qv;
        vb = cs * dv - sn * qv;
        vbk = (vb * 56756) >>> 16;
        hv = va >>> 1;
        v1 = (va * longint'(gain_q14)) >>> 14;
        v2 = ((vbk - hv) * longint'(gain_q14)) >>> 14;
        v3 = ((-vbk - hv) * longint'(gain_q14)) >>> 14;
        mn = v1;
        mx = v1;
        if (v2 < mn) mn = v2;
        if (v2 > mx) mx = v2;
        if (v3 < mn) mn = v3;
        if (v3 > mx) mx = v3;
        mid = (mn + mx) >>> 1;
        r.cmp_a = 16'(duty_to_compare(v1, mid));
        r.cmp_b = 16'(duty_to_compare(v2, mid));
        r.cmp_c = 16'(duty_to_compare(v3, mid));
        return r;
    endfunction

    // Scoreboard: an accepted item pushes its expectation, a result pops the oldest.
    always @(posedge i_clk) begin
        t_compares want;
        t_compares got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                compares_pending.push_back(row_typed ? row_result :
                    predict_compares(i_s_axis_tdata[15:0], i_s_axis_tdata[31:16],
                                     i_s_axis_tdata[47:32]));
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                got.cmp_a = o_m_axis_tdata[15:0];
                got.cmp_b = o_m_axis_tdata[31:16];
                got.cmp_c = o_m_axis_tdata[47:32];
                if (compares_pending.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result with nothing expected: a=%0d b=%0d c=%0d",
                                 got.cmp_a, got.cmp_b, got.cmp_c);
                end else begin
                    want = compares_pending.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"compare mismatch: expected a=%0d b=%0d c=%0d,",
                                      " got a=%0d b=%0d c=%0d"},
                                     want.cmp_a, want.cmp_b, want.cmp_c,
                                     got.cmp_a, got.cmp_b, got.cmp_c);
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stalls: mostly short, occasionally long, with stall-free stretches.
    always @(negedge i_clk) begin
        int hold;
        bit quiet;
        quiet = ($urandom_range(0, 3) == 0);
        hold = quiet ? $urandom_range(50, 200) : 1;
        repeat (hold) begin
            if (quiet) begin
                i_m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end else begin
                hold = pick_gap();
                if (hold > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (hold) @(negedge i_clk);
                end
                i_m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Watchdog on cycles with no handshake on either stream.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", compares_pending.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Presents one item from a falling edge and holds it until it is accepted.
    task automatic send_command(input logic [15:0] count, input logic signed [15:0] vq,
                                input logic signed [15:0] vd, input bit typed,
                                input t_compares result);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {vd, vq, count};
        row_typed <= typed;
        row_result <= result;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_COUNTS_PER_TURN: turn_counts = value & 22'hFFFF;
            CFG_ANGLE_PER_COUNT: angle_scale = value;
            CFG_PHASE_GAIN:      gain_q14 = value & 22'h7FFF;
            CFG_PWM_PERIOD:      period = value & 22'hFFFF;
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        row_typed <= 1'b0;
        while (compares_pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY_WAIT) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_voltage();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7FFF;
        if (r == 1) return -16'sh8000;
        if (r == 2) return 16'sh0000;
        return 16'($urandom());
    endfunction

    initial begin
        t_row rows[$];
        t_compares mid_duty;
        t_compares none;
        logic [CFG_DATA_W-1:0] cfg_set[NUM_SETTINGS][4];
        int per_setting;

        turn_counts = RST_COUNTS_PER_TURN;
        angle_scale = RST_ANGLE_PER_COUNT;
        gain_q14 = RST_PHASE_GAIN;
        period = RST_PWM_PERIOD;
        mid_duty = '{16'd500, 16'd500, 16'd500};
        none = '0;

        // Zero command sits at half duty on every phase; other rows use the predictor.
        rows = '{
            '{16'd0,     16'sh0000,  16'sh0000,  1'b1, mid_duty},
            '{16'd65535, 16'sh0000,  16'sh0000,  1'b1, mid_duty},
            '{16'd0,     16'sh7FFF,  16'sh0000,  1'b0, none},
            '{16'd0,     -16'sh8000, 16'sh0000,  1'b0, none},
            '{16'd0,     16'sh0000,  16'sh7FFF,  1'b0, none},
            '{16'd0,     16'sh0000,  -16'sh8000, 1'b0, none},
            '{16'd1024,  16'sh7FFF,  16'sh7FFF,  1'b0, none},
            '{16'd2048,  -16'sh8000, -16'sh8000, 1'b0, none},
            '{16'd3072,  16'sh7FFF,  -16'sh8000, 1'b0, none},
            '{16'd4095,  -16'sh8000, 16'sh7FFF,  1'b0, none},
            '{16'd4096,  16'sh4000,  16'sh0000,  1'b0, none},
            '{16'd512,   16'sh2000,  -16'sh1000, 1'b0, none},
            '{16'd65535, 16'sh7FFF,  16'sh7FFF,  1'b0, none},
            '{16'd1536,  16'shAAAA,  16'sh5555,  1'b0, none},
            '{16'd2560,  16'sh5555,  16'shAAAA,  1'b0, none},
            '{16'd3584,  16'sh0001,  -16'sh0001, 1'b0, none}
        };

        // Settings: counts per turn, angle factor, gain, period. Extremes included,
        // with a zero modulus, wrapping angles, zero and full gain, zero period.
        cfg_set[0] = '{22'd0,      22'h3FFFFF, 22'd32767, 22'd65535};
        cfg_set[1] = '{22'd65535,  22'd0,      22'd0,     22'd1};
        cfg_set[2] = '{22'd1,      22'd65536,  22'd16384, 22'd0};
        cfg_set[3] = '{22'h3F0006, 22'd700000, 22'd32767, 22'd999};
        cfg_set[4] = '{22'd1000,   22'd4194303, 22'd18919, 22'd65535};
        cfg_set[5] = '{22'd360,    22'd182,    22'd25000, 22'd4000};
        cfg_set[6] = '{22'd32768,  22'd131072, 22'h3F7FFF, 22'h3FFFFF};
        cfg_set[7] = '{22'd4096,   22'd1048576, 22'd18919, 22'd1000};
        per_setting = RANDOM_ITEMS / NUM_SETTINGS;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k])
            send_command(rows[k].count, rows[k].vq, rows[k].vd, rows[k].typed,
                         rows[k].result);
        drain_pipeline();

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            write_register(CFG_COUNTS_PER_TURN, cfg_set[s][0]);
            write_register(CFG_ANGLE_PER_COUNT, cfg_set[s][1]);
            write_register(CFG_PHASE_GAIN, cfg_set[s][2]);
            write_register(CFG_PWM_PERIOD, cfg_set[s][3]);
            // A write to an unused index must leave every register alone.
            write_register(CFG_IDX_UNUSED, 22'($urandom()));
            for (int n = 0; n < per_setting; n++) begin
                if (n % 60 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
                send_command(16'($urandom()), pick_voltage(), pick_voltage(), 1'b0, none);
            end
            quiet_sender = 1'b0;
            drain_pipeline();
        end

        $display("covered %0d items and %0d results over %0d register settings",
                 items_sent, results_seen, NUM_SETTINGS + 1);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && compares_pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: filelist.f
hdl/esvm_pkg.sv
hdl/encoder_angle_svpwm_modulator.sv
verif/tb_encoder_angle_svpwm_modulator.sv
